// ===== hdl/bbd_pkg.sv =====
// Package: constants, types and arithmetic helpers for the Bayer demosaic.
package bbd_pkg;
	localparam int MaxWidth  = 4096;
	localparam int PixBits   = 16;
	localparam int ColBits   = $clog2(MaxWidth);
	localparam int WBits     = 13;
	localparam int HBits     = 16;
	localparam int QDepth    = 4;
	localparam int QBits     = $clog2(QDepth);

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_PHASE  = 2'd2;

	// work from the front to the back: one column of three samples plus an emit flag
	typedef struct packed {
		logic [PixBits-1:0] top;
		logic [PixBits-1:0] mid;
		logic [PixBits-1:0] bot;
		logic               emit;
	} col_t;

	// floor(sum/n) for n in 1..4, sum up to 4*65535
	function automatic logic [PixBits-1:0] mean_f(input logic [PixBits+1:0] s,
		input logic [2:0] n);
		logic [PixBits+1:0] q;
		logic [PixBits+19:0] p;
		begin
			p = '0;
			case (n)
				3'd1: q = s;
				3'd2: q = s >> 1;
				3'd3: begin
					p = s * 20'd349526;
					q = p[PixBits+19:20];
				end
				3'd4: q = s >> 2;
				default: q = '0;
			endcase
			mean_f = q[PixBits-1:0];
		end
	endfunction
endpackage

// ===== hdl/bbd_front.sv =====
// Front end: input position tracking, line stores and column build.
module bbd_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      restart,
	input  logic [bbd_pkg::WBits-1:0] w_eff,
	input  logic [bbd_pkg::HBits-1:0] h_eff,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      in_func,
	input  logic [bbd_pkg::PixBits-1:0] in_sample,
	output logic                      col_valid,
	output bbd_pkg::col_t             col,
	input  logic                      q_full
);
	import bbd_pkg::*;

	logic [PixBits-1:0] mem_a [MaxWidth];
	logic [PixBits-1:0] mem_b [MaxWidth];
	logic [ColBits:0]   in_col_q;
	logic [HBits:0]     in_row_q;
	logic               draining, take, act;
	logic [ColBits-1:0] ix;
	logic               valid_s1;
	logic [PixBits-1:0] bot_s1, top_s1, mid_s1;
	logic               emit_s1, wr_s1;
	logic [ColBits-1:0] ix_s1;
	logic               emit_w;

	assign draining = in_row_q >= {1'b0, h_eff};
	// a pending stage-1 word plus queue slots bound stalls
	assign in_ready = !q_full && !restart;
	assign take     = in_valid && in_ready;
	assign act      = take && !(in_func && !draining);
	assign ix       = in_col_q[ColBits-1:0];
	assign emit_w   = draining || (in_row_q >= 17'd2) ||
		(in_row_q == 17'd1 && in_col_q >= 13'd1);

	always_ff @(posedge clk) begin
		if (act) begin
			top_s1 <= mem_b[ix];
			mid_s1 <= mem_a[ix];
		end
		if (wr_s1) begin
			mem_b[ix_s1] <= mid_s1;
			mem_a[ix_s1] <= bot_s1;
		end
	end

	// line store write-back follows the read in the next cycle
	always_ff @(posedge clk) begin
		if (act) begin
			bot_s1 <= draining ? '0 : in_sample;
			emit_s1 <= emit_w;
			ix_s1 <= ix;
		end
	end

	// row h+1 is reached only by the drain word that yields end_of_frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			valid_s1 <= 1'b0;
			wr_s1    <= 1'b0;
		end else if (restart) begin
			in_col_q <= '0;
			in_row_q <= '0;
			valid_s1 <= 1'b0;
			wr_s1    <= 1'b0;
		end else begin
			valid_s1 <= act;
			wr_s1    <= act && !draining;
			if (act) begin
				if (in_row_q > {1'b0, h_eff}) begin
					in_col_q <= '0;
					in_row_q <= '0;
				end else if (in_col_q + 13'd1 >= {1'b0, w_eff}) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 17'd1;
				end else begin
					in_col_q <= in_col_q + 13'd1;
				end
			end
		end
	end

	// width >= 2 so a read never hits the column being written in the same cycle
	assign col_valid = valid_s1;
	assign col.top   = top_s1;
	assign col.mid   = mid_s1;
	assign col.bot   = bot_s1;
	assign col.emit  = emit_s1;
endmodule

// ===== hdl/bbd_fifo.sv =====
// Small queue of columns between front and back.
module bbd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          flush,
	input  logic          wr,
	input  bbd_pkg::col_t wdata,
	input  logic          rd,
	output logic          nonempty,
	output bbd_pkg::col_t rdata,
	output logic          almost_full
);
	import bbd_pkg::*;

	col_t            mem_q [QDepth];
	logic [QBits-1:0] wp_q, rp_q;
	logic [QBits:0]  cnt_q;

	assign nonempty    = cnt_q != '0;
	assign rdata       = mem_q[rp_q];
	// one word may still be in flight in the front stage
	assign almost_full = cnt_q >= (QBits+1)'(QDepth - 1);

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else if (flush) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QBits+1)'(wr) - (QBits+1)'(rd);
		end
	end
endmodule

// ===== hdl/bbd_back.sv =====
// Back end: 3x3 window, interpolation and output register.
module bbd_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      restart,
	input  logic [bbd_pkg::WBits-1:0] w_eff,
	input  logic [bbd_pkg::HBits-1:0] h_eff,
	input  logic [1:0]                phase,
	input  logic                      col_avail,
	input  bbd_pkg::col_t             col,
	output logic                      col_take,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [bbd_pkg::PixBits-1:0] out_red,
	output logic [bbd_pkg::PixBits-1:0] out_green,
	output logic [bbd_pkg::PixBits-1:0] out_blue,
	output logic                      out_eor,
	output logic                      out_eof
);
	import bbd_pkg::*;

	logic [PixBits-1:0] win_q [9];
	logic [ColBits:0]   ox_q;
	logic [HBits:0]     oy_q;
	logic               calc_s1;
	logic               ov_q;
	logic [PixBits-1:0] r_q, g_q, b_q;
	logic               eor_q, eof_q;
	logic               out_free;

	// stage s1: window updated; compute from window when calc_s1
	assign out_free = !ov_q || out_ready;
	assign col_take = col_avail && (!calc_s1 || out_free);

	logic lf, rt, up, dn, xo, yo, eor, eof;
	logic [PixBits+1:0] hs, vs, ds, cs;
	logic [2:0] hn, vn, dnm, cn;
	logic [PixBits-1:0] rr, gg, bb, own;

	always_comb begin
		lf = ox_q != '0;
		rt = ox_q + 13'd1 < {1'b0, w_eff};
		up = oy_q != '0;
		dn = oy_q + 17'd1 < {1'b0, h_eff};
		xo = ox_q[0] ^ phase[0];
		yo = oy_q[0] ^ phase[1];
		own = win_q[4];
		hs = '0; hn = '0; vs = '0; vn = '0; ds = '0; dnm = '0;
		if (lf) begin hs = hs + 18'(win_q[3]); hn = hn + 3'd1; end
		if (rt) begin hs = hs + 18'(win_q[5]); hn = hn + 3'd1; end
		if (up) begin vs = vs + 18'(win_q[1]); vn = vn + 3'd1; end
		if (dn) begin vs = vs + 18'(win_q[7]); vn = vn + 3'd1; end
		if (lf && up) begin ds = ds + 18'(win_q[0]); dnm = dnm + 3'd1; end
		if (rt && up) begin ds = ds + 18'(win_q[2]); dnm = dnm + 3'd1; end
		if (rt && dn) begin ds = ds + 18'(win_q[8]); dnm = dnm + 3'd1; end
		if (lf && dn) begin ds = ds + 18'(win_q[6]); dnm = dnm + 3'd1; end
		cs = hs + vs;
		cn = hn + vn;
		if (!xo && !yo) begin
			rr = own; gg = mean_f(cs, cn); bb = mean_f(ds, dnm);
		end else if (xo && yo) begin
			rr = mean_f(ds, dnm); gg = mean_f(cs, cn); bb = own;
		end else if (!yo) begin
			rr = mean_f(hs, hn); gg = own; bb = mean_f(vs, vn);
		end else begin
			rr = mean_f(vs, vn); gg = own; bb = mean_f(hs, hn);
		end
		eor = ox_q + 13'd1 >= {1'b0, w_eff};
		eof = eor && (oy_q + 17'd1 >= {1'b0, h_eff});
	end

	always_ff @(posedge clk) begin
		if (col_take) begin
			win_q[0] <= win_q[1]; win_q[1] <= win_q[2]; win_q[2] <= col.top;
			win_q[3] <= win_q[4]; win_q[4] <= win_q[5]; win_q[5] <= col.mid;
			win_q[6] <= win_q[7]; win_q[7] <= win_q[8]; win_q[8] <= col.bot;
		end
		if (calc_s1 && out_free) begin
			r_q <= rr; g_q <= gg; b_q <= bb; eor_q <= eor; eof_q <= eof;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calc_s1 <= 1'b0; ov_q <= 1'b0; ox_q <= '0; oy_q <= '0;
		end else if (restart) begin
			calc_s1 <= 1'b0; ov_q <= 1'b0; ox_q <= '0; oy_q <= '0;
		end else begin
			if (out_free) ov_q <= calc_s1;
			if (!calc_s1 || out_free) calc_s1 <= col_take && col.emit;
			if (calc_s1 && out_free) begin
				if (eof) begin
					ox_q <= '0; oy_q <= '0;
				end else if (eor) begin
					ox_q <= '0; oy_q <= oy_q + 17'd1;
				end else begin
					ox_q <= ox_q + 13'd1;
				end
			end
		end
	end

	assign out_valid = ov_q;
	assign out_red   = r_q;
	assign out_green = g_q;
	assign out_blue  = b_q;
	assign out_eor   = eor_q;
	assign out_eof   = eof_q;
endmodule

// ===== hdl/bilinear_bayer_demosaic.sv =====
// Top level of the streaming bilinear Bayer demosaic.
// Raw Bayer samples enter in raster order, one word per cycle unless stalled;
// each yields at most one RGB word, lagging by one row plus one pixel. After a
// frame's last sample, send drain words (func=1) to flush the final W+1 pixels.
// Sustained rate is one word per clock when the output is not back-pressured; a
// four-entry column queue decouples the front end from the window/mean back end
// and the output register. A write to the width, height or phase register
// restarts the frame. Width is clamped to [2,4096], height to at least 2.
module bilinear_bayer_demosaic (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // raw_sample
	input  logic        s_axis_tuser,  // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // red, green, blue
	output logic        m_axis_tlast,  // end_of_row
	output logic        m_axis_tuser,  // end_of_frame
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import bbd_pkg::*;

	logic [WBits-1:0] width_q, w_eff;
	logic [HBits-1:0] height_q, h_eff;
	logic [1:0]       phase_q;
	logic             restart;
	logic             col_valid, q_full, q_ne, q_rd;
	col_t             col_in, col_out;

	assign restart = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
		cfg_index == REG_PHASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 13'd640; height_q <= 16'd480; phase_q <= 2'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[WBits-1:0];
				REG_HEIGHT: height_q <= cfg_data;
				REG_PHASE:  phase_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign w_eff = (width_q < 13'd2) ? 13'd2 :
		(width_q > 13'(MaxWidth)) ? 13'(MaxWidth) : width_q;
	assign h_eff = (height_q < 16'd2) ? 16'd2 : height_q;

	bbd_front u_front (
		.clk, .arst_n, .restart, .w_eff, .h_eff,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_func(s_axis_tuser), .in_sample(s_axis_tdata),
		.col_valid, .col(col_in), .q_full
	);

	bbd_fifo u_fifo (
		.clk, .arst_n, .flush(restart), .wr(col_valid), .wdata(col_in),
		.rd(q_rd), .nonempty(q_ne), .rdata(col_out), .almost_full(q_full)
	);

	bbd_back u_back (
		.clk, .arst_n, .restart, .w_eff, .h_eff, .phase(phase_q),
		.col_avail(q_ne), .col(col_out), .col_take(q_rd),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_red(m_axis_tdata[15:0]), .out_green(m_axis_tdata[31:16]),
		.out_blue(m_axis_tdata[47:32]), .out_eor(m_axis_tlast),
		.out_eof(m_axis_tuser)
	);
endmodule
